// File: src/clock_offset_estimator_core_defines.svh
// Assertion macros for the clock offset estimator.
`ifndef CLOCK_OFFSET_ESTIMATOR_CORE_DEFINES_SVH
`define CLOCK_OFFSET_ESTIMATOR_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define COE_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define COE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/coe_pkg.sv
package coe_pkg;

  localparam int unsigned WindowDepth = 8;
  localparam int unsigned IdxW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned CntW = $clog2(WindowDepth + 1);

  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_ESTIMATE = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_RESP_BACK    = 3'd1,
    ST_INIT_BACK    = 3'd2,
    ST_NEG_RTT      = 3'd3,
    ST_OFFSET_RANGE = 3'd4,
    ST_ORIENT_RANGE = 3'd5,
    ST_EMPTY        = 3'd6,
    ST_PEER_RANGE   = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_CHECK,
    S_SHIFT,
    S_SCAN,
    S_SMOOTH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] initiator_send_time;
    logic [63:0] responder_receive_time;
    logic [63:0] responder_send_time;
    logic [63:0] initiator_receive_time;
    logic [63:0] local_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [63:0] sample_offset;
    logic [63:0]        sample_round_trip;
    logic signed [63:0] smoothed_offset;
    logic [63:0]        minimum_round_trip;
    logic               filter_valid;
    logic [63:0]        peer_time;
  } out_item_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [63:0]     woff;
    logic [63:0]     wrtt;
    logic [IdxW-1:0] raddr;
  } mem_ctl_t;

endpackage

// File: src/coe_window_ram.sv
module coe_window_ram (
  input  logic                  clk,
  input  coe_pkg::mem_ctl_t     ctl,
  output logic [63:0]           roff,
  output logic [63:0]           rrtt
);

  logic [127:0] mem [coe_pkg::WindowDepth];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= {ctl.woff, ctl.wrtt};
    end
    {roff, rrtt} <= mem[ctl.raddr];
  end

endmodule

// File: src/coe_sample_calc.sv
module coe_sample_calc (
  input  logic               clk,
  input  coe_pkg::in_item_t  item,
  input  logic               responder,
  output logic [2:0]         status,
  output logic [63:0]        off,
  output logic [63:0]        rtt
);

  logic [64:0] rsum;
  logic [64:0] isum;
  logic        neg;
  logic [64:0] diff;
  logic [63:0] half;
  logic [63:0] d21;
  logic [63:0] d30;
  logic [63:0] soff;
  logic [2:0]  st;

  always_comb begin
    rsum = {1'b0, item.responder_receive_time} + {1'b0, item.responder_send_time};
    isum = {1'b0, item.initiator_send_time} + {1'b0, item.initiator_receive_time};
    neg  = rsum < isum;
    diff = neg ? (isum - rsum) : (rsum - isum);
    half = diff[64:1];
    d21  = item.responder_send_time - item.responder_receive_time;
    d30  = item.initiator_receive_time - item.initiator_send_time;
    soff = neg ? (64'd0 - half) : half;
    st   = coe_pkg::ST_OK;
    priority if (item.responder_send_time < item.responder_receive_time) begin
      st = coe_pkg::ST_RESP_BACK;
    end else if (item.initiator_receive_time < item.initiator_send_time) begin
      st = coe_pkg::ST_INIT_BACK;
    end else if (d21 > d30) begin
      st = coe_pkg::ST_NEG_RTT;
    end else if ((!neg && half[63]) || (neg && half > 64'h8000_0000_0000_0000)) begin
      st = coe_pkg::ST_OFFSET_RANGE;
    end else if (responder && soff == 64'h8000_0000_0000_0000) begin
      st = coe_pkg::ST_ORIENT_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    status <= st;
    off    <= responder ? (64'd0 - soff) : soff;
    rtt    <= d30 - d21;
  end

endmodule

// File: src/clock_offset_estimator_core.sv
// Clock offset estimator. Each transfer on in_* yields one transfer on out_*.
// A sample command passes through timestamp arithmetic and checks (S_CALC,
// S_CHECK); once the window is full, a shift with a read and then a write per
// shifted entry (S_SHIFT); a scan that reads the window memory one entry per
// cycle to find the least round trip (S_SCAN); a smoothing step (S_SMOOTH)
// and a step to post the result (S_DONE). While the window fills, the new
// entry is written during the checks and the shift is skipped. A rejected
// sample goes from the checks to S_DONE; estimate, clear and idle commands go
// straight to S_DONE. One item is in process at a time;
// the next is taken once the result sits in the output register, while that
// result waits to be taken, and a later result waits until it is taken.
`include "clock_offset_estimator_core_defines.svh"

module clock_offset_estimator_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  coe_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output coe_pkg::out_item_t  out_data
);

  localparam int unsigned IW = coe_pkg::IdxW;
  localparam int unsigned CW = coe_pkg::CntW;
  localparam logic [CW-1:0] Full = CW'(coe_pkg::WindowDepth);

  coe_pkg::state_t   state, state_next;
  coe_pkg::in_item_t item;
  coe_pkg::mem_ctl_t mctl;
  logic              responder;
  logic [CW-1:0]     count;
  logic [63:0]       filt;
  logic [63:0]       least;
  logic              have;
  logic [2:0]        c_status;
  logic [63:0]       c_off, c_rtt, m_off, m_rtt;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     rptr;
  logic              rd_pend;
  logic [63:0]       best_off, best_rtt;
  logic              last;
  logic              done_go;
  logic [63:0]       step_up, step_dn, smooth_val;
  logic [64:0]       psum;
  logic [63:0]       mag;
  logic [2:0]        est_status;
  logic [63:0]       peer;

  assign in_ready = (state == coe_pkg::S_IDLE);
  assign done_go  = (state == coe_pkg::S_DONE) && (!out_valid || out_ready);

  coe_sample_calc u_calc (
    .clk       (clk),
    .item      (item),
    .responder (responder),
    .status    (c_status),
    .off       (c_off),
    .rtt       (c_rtt)
  );

  coe_window_ram u_ram (
    .clk  (clk),
    .ctl  (mctl),
    .roff (m_off),
    .rrtt (m_rtt)
  );

  always_comb begin
    step_up = (best_off - filt) >> 3;
    step_dn = (filt - best_off) >> 3;
    if (best_off == filt) begin
      smooth_val = filt;
    end else if ($signed(filt) < $signed(best_off)) begin
      smooth_val = filt + step_up;
    end else begin
      smooth_val = filt - step_dn;
    end
    mag  = 64'd0 - filt;
    psum = {1'b0, item.local_time} + {1'b0, filt};
    est_status = coe_pkg::ST_OK;
    peer = 64'd0;
    if (!have) begin
      est_status = coe_pkg::ST_EMPTY;
    end else if (!filt[63]) begin
      if (psum[64]) est_status = coe_pkg::ST_PEER_RANGE;
      else peer = psum[63:0];
    end else begin
      if (mag > item.local_time) est_status = coe_pkg::ST_PEER_RANGE;
      else peer = item.local_time - mag;
    end
  end

  // shift copies entry ptr+1 down to ptr; reads one ahead
  always_comb begin
    state_next = state;
    mctl.we    = 1'b0;
    mctl.waddr = IW'(ptr);
    mctl.woff  = m_off;
    mctl.wrtt  = m_rtt;
    mctl.raddr = IW'(rptr);
    last       = 1'b0;
    unique case (state)
      coe_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (coe_pkg::cmd_t'(in_data.cmd))
            coe_pkg::CMD_SAMPLE: state_next = coe_pkg::S_CALC;
            default:             state_next = coe_pkg::S_DONE;
          endcase
        end
      end
      coe_pkg::S_CALC: begin
        state_next = coe_pkg::S_CHECK;
      end
      coe_pkg::S_CHECK: begin
        if (c_status != coe_pkg::ST_OK) begin
          state_next = coe_pkg::S_DONE;
        end else if (count == Full) begin
          state_next = coe_pkg::S_SHIFT;
        end else begin
          mctl.we    = 1'b1;
          mctl.waddr = IW'(count);
          mctl.woff  = c_off;
          mctl.wrtt  = c_rtt;
          state_next = coe_pkg::S_SCAN;
        end
      end
      coe_pkg::S_SHIFT: begin
        if (ptr == Full - CW'(1)) begin
          mctl.we    = 1'b1;
          mctl.woff  = c_off;
          mctl.wrtt  = c_rtt;
          state_next = coe_pkg::S_SCAN;
        end else if (rd_pend) begin
          mctl.we = 1'b1;
        end
      end
      coe_pkg::S_SCAN: begin
        last = rd_pend && (ptr == count - CW'(1));
        if (last) state_next = coe_pkg::S_SMOOTH;
      end
      coe_pkg::S_SMOOTH: begin
        state_next = coe_pkg::S_DONE;
      end
      coe_pkg::S_DONE: begin
        if (done_go) state_next = coe_pkg::S_IDLE;
      end
      default: state_next = coe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= coe_pkg::S_IDLE;
      responder <= 1'b0;
      count     <= '0;
      filt      <= '0;
      least     <= '0;
      have      <= 1'b0;
      out_valid <= 1'b0;
      ptr       <= '0;
      rptr      <= '0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) responder <= cfg_wdata;
      if (out_valid && out_ready && !done_go) out_valid <= 1'b0;
      unique case (state)
        coe_pkg::S_IDLE: begin
          if (in_valid && in_ready) item <= in_data;
          ptr     <= '0;
          rptr    <= CW'(1);
          rd_pend <= 1'b0;
        end
        coe_pkg::S_CHECK: begin
          if (c_status == coe_pkg::ST_OK) begin
            if (count != Full) count <= count + CW'(1);
            rptr    <= (count == Full) ? CW'(1) : '0;
            ptr     <= '0;
            rd_pend <= 1'b0;
          end
        end
        coe_pkg::S_SHIFT: begin
          if (ptr == Full - CW'(1)) begin
            ptr     <= '0;
            rptr    <= '0;
            rd_pend <= 1'b0;
          end else if (rd_pend) begin
            ptr     <= ptr + CW'(1);
            rptr    <= rptr + CW'(1);
            rd_pend <= 1'b0;
          end else begin
            rd_pend <= 1'b1;
          end
        end
        coe_pkg::S_SCAN: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
            rptr    <= rptr + CW'(1);
          end else begin
            if (ptr == '0 || m_rtt <= best_rtt) begin
              best_off <= m_off;
              best_rtt <= m_rtt;
            end
            ptr  <= ptr + CW'(1);
            rptr <= rptr + CW'(1);
          end
        end
        coe_pkg::S_SMOOTH: begin
          least <= best_rtt;
          filt  <= have ? smooth_val : best_off;
          have  <= 1'b1;
        end
        coe_pkg::S_DONE: begin
          if (done_go) begin
            out_valid <= 1'b1;
            if (coe_pkg::cmd_t'(item.cmd) == coe_pkg::CMD_CLEAR) begin
              count <= '0;
              filt  <= '0;
              least <= '0;
              have  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_data.status             <= '0;
      out_data.sample_offset      <= '0;
      out_data.sample_round_trip  <= '0;
      out_data.smoothed_offset    <= filt;
      out_data.minimum_round_trip <= least;
      out_data.filter_valid       <= have;
      out_data.peer_time          <= '0;
      unique case (coe_pkg::cmd_t'(item.cmd))
        coe_pkg::CMD_SAMPLE: begin
          out_data.status <= c_status;
          if (c_status == coe_pkg::ST_OK) begin
            out_data.sample_offset     <= c_off;
            out_data.sample_round_trip <= c_rtt;
          end
        end
        coe_pkg::CMD_ESTIMATE: begin
          out_data.status    <= est_status;
          out_data.peer_time <= peer;
        end
        coe_pkg::CMD_CLEAR: begin
          out_data.smoothed_offset    <= '0;
          out_data.minimum_round_trip <= '0;
          out_data.filter_valid       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  `COE_ASSERT_IMPL(a_no_accept_busy, clk, rst, state != coe_pkg::S_IDLE, !in_ready, "accept while busy")
  `COE_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= Full, "window count overflow")
  `COE_ASSERT_NEXT(a_done_valid, clk, rst, state == coe_pkg::S_DONE, out_valid, "result not posted")
  `COE_ASSERT_IMPL(a_scan_have, clk, rst, state == coe_pkg::S_SMOOTH, count != '0, "scan on empty window")

endmodule
